/* src/luhn_pkg.sv */
// shared types and constants for the luhn card number classifier
`timescale 1ns / 1ps
`default_nettype none
package luhn_pkg;

	localparam int CARD_W         = 54;
	localparam int BCD_DIGITS     = 17;
	localparam int BCD_W          = 4 * BCD_DIGITS;
	localparam int COUNT_W        = 5;
	localparam int LEAD2_W        = 7;
	localparam int MAX_DIGITS_DEF = 16;
	localparam int CNT_W          = 6;

	localparam logic [3:0]         LEAD_BRAND_ONE = 4'd4;
	localparam logic [LEAD2_W-1:0] LEAD2_TWO_A    = 7'd34;
	localparam logic [LEAD2_W-1:0] LEAD2_TWO_B    = 7'd37;
	localparam logic [COUNT_W-1:0] LEN_ONE_SHORT  = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_ONE_LONG   = 5'd16;
	localparam logic [COUNT_W-1:0] LEN_TWO        = 5'd15;

	typedef enum logic [1:0] {
		VERDICT_FAIL      = 2'd0,
		VERDICT_BRAND_ONE = 2'd1,
		VERDICT_BRAND_TWO = 2'd2,
		VERDICT_UNKNOWN   = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LOAD,
		ST_SCAN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} step_ctrl_t;

	typedef struct packed {
		verdict_t            verdict;
		logic [COUNT_W-1:0]  digit_count;
	} scan_result_t;

endpackage
`default_nettype wire

/* src/luhn_bcd_conv.sv */
// bit-serial binary to bcd converter (shift and add 3)
`timescale 1ns / 1ps
`default_nettype none
module luhn_bcd_conv (
	input  wire                                clk,
	input  wire luhn_pkg::step_ctrl_t          ctrl,
	input  wire [luhn_pkg::CARD_W-1:0]         card,
	output logic [luhn_pkg::BCD_W-1:0]         bcd
);

	logic [luhn_pkg::CARD_W-1:0] bin_q;
	logic [luhn_pkg::BCD_W-1:0]  bcd_q;
	logic [luhn_pkg::BCD_W-1:0]  adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < luhn_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= card;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[luhn_pkg::CARD_W-2:0], 1'b0};
			bcd_q <= {adj[luhn_pkg::BCD_W-2:0], bin_q[luhn_pkg::CARD_W-1]};
		end
	end

	assign bcd = bcd_q;

endmodule
`default_nettype wire

/* src/luhn_digit_scan.sv */
// digit-serial luhn sum, digit count and brand classification
`timescale 1ns / 1ps
`default_nettype none
module luhn_digit_scan #(
	parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
	input  wire                              clk,
	input  wire luhn_pkg::step_ctrl_t        ctrl,
	input  wire [luhn_pkg::BCD_W-1:0]        bcd,
	output luhn_pkg::scan_result_t           result
);

	logic [luhn_pkg::BCD_W-1:0]   dig_q;
	logic [luhn_pkg::COUNT_W-1:0] pos_q;
	logic [luhn_pkg::COUNT_W-1:0] count_q;
	logic [3:0]                   tot_q;
	logic [3:0]                   lead_q;
	logic [3:0]                   prev_q;
	logic [luhn_pkg::LEAD2_W-1:0] lead2_q;

	logic [3:0] d;
	logic [4:0] dbl;
	logic [3:0] v;
	logic [4:0] sum;
	logic [3:0] tot_next;
	logic [luhn_pkg::LEAD2_W-1:0] lead2_next;

	always_comb begin
		d   = dig_q[3:0];
		dbl = {d, 1'b0};
		if (!pos_q[0]) begin
			v = d;
		end else if (dbl > 5'd9) begin
			v = 4'(dbl - 5'd9);
		end else begin
			v = dbl[3:0];
		end
		sum = {1'b0, tot_q} + {1'b0, v};
		if (sum >= 5'd10) begin
			tot_next = 4'(sum - 5'd10);
		end else begin
			tot_next = sum[3:0];
		end
		// d * 10 + digit just below
		lead2_next = {d, 3'b000} + {2'b00, d, 1'b0} + {3'b000, prev_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dig_q   <= bcd;
			pos_q   <= '0;
			count_q <= '0;
			tot_q   <= '0;
			lead_q  <= '0;
			prev_q  <= '0;
			lead2_q <= '0;
		end else if (ctrl.step) begin
			dig_q  <= {4'd0, dig_q[luhn_pkg::BCD_W-1:4]};
			pos_q  <= pos_q + 1'b1;
			tot_q  <= tot_next;
			prev_q <= d;
			if (d != 4'd0) begin
				count_q <= pos_q + 1'b1;
				lead_q  <= d;
				lead2_q <= lead2_next;
			end
		end
	end

	always_comb begin
		result.digit_count = count_q;
		priority if (count_q > luhn_pkg::COUNT_W'(MAX_DIGITS) || tot_q != 4'd0) begin
			result.verdict = luhn_pkg::VERDICT_FAIL;
		end else if (lead_q == luhn_pkg::LEAD_BRAND_ONE
				&& (count_q == luhn_pkg::LEN_ONE_SHORT || count_q == luhn_pkg::LEN_ONE_LONG)) begin
			result.verdict = luhn_pkg::VERDICT_BRAND_ONE;
		end else if (count_q == luhn_pkg::LEN_TWO
				&& (lead2_q == luhn_pkg::LEAD2_TWO_A || lead2_q == luhn_pkg::LEAD2_TWO_B)) begin
			result.verdict = luhn_pkg::VERDICT_BRAND_TWO;
		end else begin
			result.verdict = luhn_pkg::VERDICT_UNKNOWN;
		end
	end

endmodule
`default_nettype wire

/* src/luhn_card_number_classifier.sv */
// top level of the luhn card number classifier
// usage:
//   slave side takes one item per card number: s_tdata[53:0] is the number as an
//   unsigned binary integer, bits above are ignored
//   master side returns one item per card number: verdict and decimal digit count
//   the number is first turned into 17 bcd digits by shift and add 3, one input
//   bit per cycle, then the digits are walked from the least significant end,
//   one digit per cycle, building the luhn sum mod 10, the digit count and the
//   leading digits
// the bit-serial conversion and the digit-serial scan run one after the other and
//   share one step counter
// s_tready is high only while no item is at work, so one item is handled at a time
// stall: the result sits in an output register; a new item is accepted and
//   worked on while it waits, and its result is held until the register frees
// reset: arst_n clears the state machine and the output valid flag; the block
//   comes out of reset idle and ready
`timescale 1ns / 1ps
`default_nettype none
module luhn_card_number_classifier #(
	parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,   // [53:0] card_number, [55:54] zero fill
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata    // [1:0] verdict, [6:2] digit_count, [7] zero fill
);

	localparam logic [luhn_pkg::CNT_W-1:0] CONV_LAST = luhn_pkg::CNT_W'(luhn_pkg::CARD_W - 1);
	localparam logic [luhn_pkg::CNT_W-1:0] SCAN_LAST =
		luhn_pkg::CNT_W'(luhn_pkg::BCD_DIGITS - 1);

	luhn_pkg::state_t state_q, state_d;
	logic [luhn_pkg::CNT_W-1:0] cnt_q, cnt_d;

	luhn_pkg::step_ctrl_t conv_ctrl;
	luhn_pkg::step_ctrl_t scan_ctrl;
	logic [luhn_pkg::BCD_W-1:0] bcd;
	luhn_pkg::scan_result_t     result;

	logic                   out_valid_q;
	luhn_pkg::scan_result_t out_q;
	logic                   out_free;
	logic                   out_load;

	// output register frees when empty or taken this cycle
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= luhn_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		s_tready       = 1'b0;
		conv_ctrl      = '0;
		scan_ctrl      = '0;
		out_load       = 1'b0;
		unique case (state_q)
			luhn_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					conv_ctrl.load = 1'b1;
					cnt_d          = '0;
					state_d        = luhn_pkg::ST_CONV;
				end
			end
			luhn_pkg::ST_CONV: begin
				conv_ctrl.step = 1'b1;
				cnt_d          = cnt_q + 1'b1;
				if (cnt_q == CONV_LAST) begin
					state_d = luhn_pkg::ST_LOAD;
				end
			end
			luhn_pkg::ST_LOAD: begin
				// bcd digits are final, hand them to the scanner
				scan_ctrl.load = 1'b1;
				cnt_d          = '0;
				state_d        = luhn_pkg::ST_SCAN;
			end
			luhn_pkg::ST_SCAN: begin
				scan_ctrl.step = 1'b1;
				cnt_d          = cnt_q + 1'b1;
				if (cnt_q == SCAN_LAST) begin
					state_d = luhn_pkg::ST_HOLD;
				end
			end
			luhn_pkg::ST_HOLD: begin
				// wait here while the previous result is still unread
				if (out_free) begin
					out_load = 1'b1;
					state_d  = luhn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = luhn_pkg::ST_IDLE;
			end
		endcase
	end

	luhn_bcd_conv u_conv (
		.clk  (clk),
		.ctrl (conv_ctrl),
		.card (s_tdata[luhn_pkg::CARD_W-1:0]),
		.bcd  (bcd)
	);

	luhn_digit_scan #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_scan (
		.clk    (clk),
		.ctrl   (scan_ctrl),
		.bcd    (bcd),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.digit_count, out_q.verdict};

endmodule
`default_nettype wire

/* src/luhn_checker.sv */
// port-level assertions for the luhn card number classifier and their bind
`timescale 1ns / 1ps
`default_nettype none
module luhn_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [55:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [7:0]  m_tdata
);

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: no second accept right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accept");

	// a 54-bit number has at most 17 digits and the fill bit is zero
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:2] <= 5'd17 && !m_tdata[7])
		else $error("digit count out of range");

	// brand one needs 13 or 16 digits, brand two 15
	a_brand_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == luhn_pkg::VERDICT_BRAND_ONE
		|-> m_tdata[6:2] == 5'd13 || m_tdata[6:2] == 5'd16)
		else $error("brand one with wrong length");

	a_brand_two_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == luhn_pkg::VERDICT_BRAND_TWO |-> m_tdata[6:2] == 5'd15)
		else $error("brand two with wrong length");

	// input payload is only observed, not checked here
	logic unused_in;
	assign unused_in = ^s_tdata;

endmodule

bind luhn_card_number_classifier luhn_checker u_luhn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
